[hdl/pixel_histogram_accumulator_unit_assert.svh]
// Assertion macros shared by the histogram accumulator RTL.
`ifndef PIXEL_HISTOGRAM_ACCUMULATOR_UNIT_ASSERT_SVH
`define PIXEL_HISTOGRAM_ACCUMULATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define PHA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define PHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PHA_ASSERT_NOW(lbl, ante, cons, msg)

`define PHA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hdl/pha_pkg.sv]
// Types and constants of the pixel histogram accumulator.
`default_nettype none

package pha_pkg;

    localparam int ACTION_W    = 2;
    localparam int SAMPLE_W    = 8;
    localparam int FIELD_W     = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 2;
    localparam int CHSEL_W     = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_SELECT = 1'd1;

    localparam logic [CHSEL_W-1:0] CH_ZERO = 2'd0;
    localparam logic [CHSEL_W-1:0] CH_ONE  = 2'd1;
    localparam logic [CHSEL_W-1:0] CH_TWO  = 2'd2;

    // Control of the transaction in the update stage.
    typedef struct packed {
        logic    valid;
        action_t op;
        logic    hit;   // for an add, bin in range and pixel channel exists; for a read, bin in range
        logic    zero;  // bin reads as zero (never written or cleared)
        logic    fwd;   // bin takes the value written in the previous cycle
    } pha_s1_t;

endpackage

`default_nettype wire

[hdl/pha_bin_ram.sv]
// Bin counter memory: one write port, one registered read port.
`default_nettype none

module pha_bin_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 32
) (
    input  wire logic          aclk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[hdl/pha_update.sv]
// Update stage: bin value select, saturating increment and result register.
`default_nettype none

module pha_update #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire pha_pkg::pha_s1_t         s1,
    input  wire logic [COUNT_WIDTH-1:0]   ram_q,
    input  wire logic [COUNT_WIDTH-1:0]   fwd_data,
    output logic                          adv,
    output logic      [COUNT_WIDTH-1:0]   cnt_next,
    input  wire logic                     m_ready,
    output logic                          m_valid,
    output logic      [pha_pkg::FIELD_W-1:0] m_bin_count
);

    import pha_pkg::*;

    logic [COUNT_WIDTH-1:0] cur;
    logic [FIELD_W-1:0]     field_val;
    logic [FIELD_W-1:0]     result;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [FIELD_W-1:0]     m_bin_count_reg;
    logic                   read_out;

    assign cur = s1.zero ? '0 : (s1.fwd ? fwd_data : ram_q);
    assign cnt_next = (&cur) ? cur : cur + 1'b1;

    generate
        if (COUNT_WIDTH > FIELD_W) begin : g_sat
            assign field_val = (|cur[COUNT_WIDTH-1:FIELD_W]) ? '1 : cur[FIELD_W-1:0];
        end else begin : g_ext
            assign field_val = FIELD_W'(cur);
        end
    endgenerate

    assign result   = s1.hit ? field_val : '0;
    assign adv      = s1.valid && (s1.op != ACT_READ || !m_valid_reg || m_ready);
    assign read_out = adv && s1.op == ACT_READ;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (read_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (read_out) begin
            m_bin_count_reg <= result;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_bin_count = m_bin_count_reg;

endmodule

`default_nettype wire

[hdl/pixel_histogram_accumulator_unit.sv]
// Pixel histogram accumulator: top level.
// Takes one transaction per clock cycle while not stalled: add a pixel to its
// bin, read a bin, or clear all bins. The bins live in a single-port-read,
// single-port-write memory; each transaction reads its bin at acceptance and
// the update stage writes the saturated increment back in the next cycle,
// with the written value forwarded to a transaction that reads the same bin
// right behind it. A read result passes from the update stage into an output
// register and waits there on the result channel; input stalls only while a
// read sits in the update stage and that register still holds an untaken
// result. Clear needs no clearing pass: a per-bin valid flag, cleared at once
// by reset or by clear, makes the bin read as zero until it is next written.
`default_nettype none
`include "pixel_histogram_accumulator_unit_assert.svh"

module pixel_histogram_accumulator_unit #(
    parameter int BIN_COUNT   = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [pha_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [pha_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [pha_pkg::ACTION_W-1:0]     s_action,
    input  wire logic [pha_pkg::SAMPLE_W-1:0]     s_sample_zero,
    input  wire logic [pha_pkg::SAMPLE_W-1:0]     s_sample_one,
    input  wire logic [pha_pkg::SAMPLE_W-1:0]     s_sample_two,
    input  wire logic [pha_pkg::SAMPLE_W-1:0]     s_read_index,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [pha_pkg::FIELD_W-1:0]      m_bin_count
);

    import pha_pkg::*;

    localparam int AW    = $clog2(BIN_COUNT);
    localparam int DEPTH = 1 << AW;
    localparam logic [SAMPLE_W:0] BIN_LIMIT = (SAMPLE_W + 1)'(BIN_COUNT);

    logic                   color_mode_reg;
    logic [CHSEL_W-1:0]     channel_select_reg;

    logic [SAMPLE_W-1:0]    pix_idx;
    logic                   pix_ok;
    logic [SAMPLE_W-1:0]    in_idx;
    action_t                in_op;
    logic                   in_hit;
    logic [AW-1:0]          in_addr;
    logic                   accept;
    logic                   fwd_now;
    logic                   clr_now;

    pha_s1_t                s1_reg;
    pha_s1_t                s1_next;
    logic [AW-1:0]          s1_addr_reg;
    logic [COUNT_WIDTH-1:0] s1_fwd_data_reg;

    logic [DEPTH-1:0]       valid_reg;
    logic [DEPTH-1:0]       valid_next;

    logic                   s1_adv;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic [COUNT_WIDTH-1:0] ram_q;
    logic                   wr_en;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_mode_reg     <= 1'b0;
            channel_select_reg <= CH_ZERO;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COLOR_MODE:     color_mode_reg     <= cfg_wr_data[0];
                REG_CHANNEL_SELECT: channel_select_reg <= cfg_wr_data[CHSEL_W-1:0];
                default: ;
            endcase
        end
    end

    // bin index of an incoming transaction
    always_comb begin
        pix_idx = s_sample_zero;
        pix_ok  = 1'b1;
        if (color_mode_reg) begin
            case (channel_select_reg)
                CH_ZERO: pix_idx = s_sample_zero;
                CH_ONE:  pix_idx = s_sample_one;
                CH_TWO:  pix_idx = s_sample_two;
                default: pix_ok  = 1'b0;
            endcase
        end
    end

    always_comb begin
        in_op  = ACT_ADD;
        in_idx = pix_idx;
        in_hit = 1'b0;
        case (s_action)
            ACT_ADD: begin
                in_op  = ACT_ADD;
                in_idx = pix_idx;
                in_hit = pix_ok && ({1'b0, pix_idx} < BIN_LIMIT);
            end
            ACT_READ: begin
                in_op  = ACT_READ;
                in_idx = s_read_index;
                in_hit = {1'b0, s_read_index} < BIN_LIMIT;
            end
            ACT_CLEAR: begin
                in_op  = ACT_CLEAR;
                in_hit = 1'b1;
            end
            default: begin
                in_op  = ACT_ADD;
                in_hit = 1'b0;
            end
        endcase
    end

    assign in_addr = in_idx[AW-1:0];
    assign s_ready = !s1_reg.valid || s1_adv;
    assign accept  = s_valid && s_ready;

    assign wr_en   = s1_reg.valid && s1_reg.op == ACT_ADD && s1_reg.hit;
    assign clr_now = s1_reg.valid && s1_reg.op == ACT_CLEAR;
    assign fwd_now = wr_en && (s1_addr_reg == in_addr);

    // update stage control
    always_comb begin
        s1_next = s1_reg;
        if (accept) begin
            s1_next.valid = 1'b1;
            s1_next.op    = in_op;
            s1_next.hit   = in_hit;
            s1_next.zero  = clr_now || (!fwd_now && !valid_reg[in_addr]);
            s1_next.fwd   = !clr_now && fwd_now;
        end else if (s1_adv) begin
            s1_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
        end else begin
            s1_reg <= s1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg     <= in_addr;
            s1_fwd_data_reg <= cnt_next;
        end
    end

    // per-bin written flags
    always_comb begin
        valid_next = valid_reg;
        if (clr_now) begin
            valid_next = '0;
        end else if (wr_en) begin
            valid_next[s1_addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    pha_bin_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (COUNT_WIDTH)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (ram_q),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (cnt_next)
    );

    pha_update #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_update (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s1          (s1_reg),
        .ram_q       (ram_q),
        .fwd_data    (s1_fwd_data_reg),
        .adv         (s1_adv),
        .cnt_next    (cnt_next),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_bin_count (m_bin_count)
    );

    `PHA_ASSERT_NOW(a_clear_no_stall, clr_now, s_ready, "clear stalled the input")
    `PHA_ASSERT_NEXT(a_clear_empties, clr_now, valid_reg == '0, "bins still marked after clear")
    `PHA_ASSERT_NEXT(a_write_marks, wr_en, valid_reg[$past(s1_addr_reg)], "written bin not marked")
    `PHA_ASSERT_NEXT(a_fwd_match, accept,
        s1_reg.fwd == ($past(wr_en) && $past(s1_addr_reg) == s1_addr_reg),
        "forwarding flag does not match the previous write")

endmodule

`default_nettype wire

[test/pixel_histogram_monitor.sv]
// Bus monitor for the histogram accumulator: keeps a bin model and checks every read result.
`timescale 1ns / 1ps

module pixel_histogram_monitor #(
    parameter int BIN_COUNT   = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pha_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pha_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [pha_pkg::ACTION_W-1:0]    s_action,
    input  logic [pha_pkg::SAMPLE_W-1:0]    s_sample_zero,
    input  logic [pha_pkg::SAMPLE_W-1:0]    s_sample_one,
    input  logic [pha_pkg::SAMPLE_W-1:0]    s_sample_two,
    input  logic [pha_pkg::SAMPLE_W-1:0]    s_read_index,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [pha_pkg::FIELD_W-1:0]     m_bin_count,
    output int                              fail_count,
    output int                              reads_pending
);

    import pha_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;
    localparam logic [FIELD_W-1:0]     FIELD_TOP = '1;

    logic [COUNT_WIDTH-1:0] bin_model [BIN_COUNT];
    logic [FIELD_W-1:0]     expected_counts [$];
    logic                   color_on;
    logic [CHSEL_W-1:0]     chan_sel;
    int                     mismatches = 0;

    always @(posedge aclk) begin
        logic [63:0]         wide;
        logic [SAMPLE_W-1:0] pix;
        logic                pix_ok;
        logic [FIELD_W-1:0]  want;
        if (!aresetn) begin
            foreach (bin_model[i]) bin_model[i] = '0;
            expected_counts.delete();
            color_on = 1'b0;
            chan_sel = CH_ZERO;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_counts.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected bin_count, expected none, actual %0d",
                             $time, m_bin_count);
                end else begin
                    want = expected_counts.pop_front();
                    if (m_bin_count !== want) begin
                        mismatches++;
                        $display("%0t: bin_count mismatch, expected %0d, actual %0d",
                                 $time, want, m_bin_count);
                    end
                end
            end
            if (s_valid && s_ready) begin
                case (s_action)
                    ACT_ADD: begin
                        pix_ok = 1'b1;
                        pix    = s_sample_zero;
                        if (color_on) begin
                            case (chan_sel)
                                CH_ZERO: pix = s_sample_zero;
                                CH_ONE:  pix = s_sample_one;
                                CH_TWO:  pix = s_sample_two;
                                default: pix_ok = 1'b0;
                            endcase
                        end
                        if (pix_ok && pix < BIN_COUNT && bin_model[pix] != COUNT_TOP)
                            bin_model[pix] = bin_model[pix] + 1'b1;
                    end
                    ACT_READ: begin
                        wide = (s_read_index < BIN_COUNT) ? 64'(bin_model[s_read_index]) : '0;
                        expected_counts.push_back((wide > 64'(FIELD_TOP)) ? FIELD_TOP
                                                                          : FIELD_W'(wide));
                    end
                    ACT_CLEAR: begin
                        foreach (bin_model[i]) bin_model[i] = '0;
                    end
                    default: ;
                endcase
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_COLOR_MODE:     color_on = cfg_wr_data[0];
                    REG_CHANNEL_SELECT: chan_sel = cfg_wr_data[CHSEL_W-1:0];
                    default: ;
                endcase
            end
        end
        fail_count    <= mismatches;
        reads_pending <= expected_counts.size();
    end

endmodule

[test/pixel_histogram_accumulator_unit_test.sv]
// Testbench top for the pixel histogram accumulator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module pixel_histogram_accumulator_unit_test;
    import pha_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_SPARE     = 2'd3;
    localparam logic [CHSEL_W-1:0]  CH_NONE       = 2'd3;
    localparam int                  SETTLE_CYCLES = 6;
    localparam int                  CYCLE_LIMIT   = 300000;
    localparam int                  RANDOM_ITEMS  = 1400;
    localparam int                  PHASES        = 6;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [ACTION_W-1:0]    s_action;
    logic [SAMPLE_W-1:0]    s_sample_zero;
    logic [SAMPLE_W-1:0]    s_sample_one;
    logic [SAMPLE_W-1:0]    s_sample_two;
    logic [SAMPLE_W-1:0]    s_read_index;
    logic                   m_valid;
    logic                   m_ready;
    logic [FIELD_W-1:0]     m_bin_count;
    int                     fail_count;
    int                     reads_pending;
    int                     cycle_count = 0;
    logic                   idle_on;

    pixel_histogram_accumulator_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_sample_zero (s_sample_zero),
        .s_sample_one  (s_sample_one),
        .s_sample_two  (s_sample_two),
        .s_read_index  (s_read_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bin_count   (m_bin_count)
    );

    pixel_histogram_monitor u_monitor (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [SAMPLE_W-1:0] s0,
                             input logic [SAMPLE_W-1:0] s1, input logic [SAMPLE_W-1:0] s2,
                             input logic [SAMPLE_W-1:0] ri);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_sample_zero <= s0;
        s_sample_one  <= s1;
        s_sample_two  <= s2;
        s_read_index  <= ri;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_for_counts();
        s_valid <= 1'b0;
        do @(posedge aclk); while (reads_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic color, input logic [CHSEL_W-1:0] chan);
        wait_for_counts();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_COLOR_MODE;
        cfg_wr_data <= CFG_DATA_W'(color);
        @(posedge aclk);
        cfg_index   <= REG_CHANNEL_SELECT;
        cfg_wr_data <= chan;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // most samples land on a few low and high bins so counts build up
    function automatic logic [SAMPLE_W-1:0] pick_bin();
        int hot;
        hot = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            return SAMPLE_W'($urandom);
        return (hot < 4) ? SAMPLE_W'(hot) : SAMPLE_W'(248 + hot);
    endfunction

    task automatic random_item();
        logic [ACTION_W-1:0] act;
        int                  roll;
        roll = $urandom_range(0, 99);
        if (roll < 62)
            act = ACT_ADD;
        else if (roll < 95)
            act = ACT_READ;
        else if (roll < 97)
            act = ACT_CLEAR;
        else
            act = ACT_SPARE;
        send_item(act, pick_bin(), pick_bin(), pick_bin(), pick_bin());
    endtask

    initial begin
        logic                 phase_color [PHASES];
        logic [CHSEL_W-1:0]   phase_chan [PHASES];
        phase_color = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
        phase_chan  = '{CH_ZERO, CH_ZERO, CH_ONE, CH_TWO, CH_NONE, CH_TWO};
        aresetn       <= 1'b0;
        idle_on       <= 1'b1;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= REG_COLOR_MODE;
        cfg_wr_data   <= '0;
        s_valid       <= 1'b0;
        s_action      <= ACT_ADD;
        s_sample_zero <= '0;
        s_sample_one  <= '0;
        s_sample_two  <= '0;
        s_read_index  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // gray mode after reset
        send_item(ACT_READ, 8'h00, 8'h00, 8'h00, 8'd0);
        send_item(ACT_READ, 8'hff, 8'hff, 8'hff, 8'd255);
        send_item(ACT_ADD, 8'd0, 8'hff, 8'hff, 8'hff);
        send_item(ACT_ADD, 8'd255, 8'h00, 8'h00, 8'h00);
        send_item(ACT_ADD, 8'd255, 8'h00, 8'h00, 8'h00);
        send_item(ACT_READ, 8'h00, 8'h00, 8'h00, 8'd255);
        send_item(ACT_READ, 8'h00, 8'h00, 8'h00, 8'd0);
        send_item(ACT_SPARE, 8'd7, 8'd7, 8'd7, 8'd7);
        send_item(ACT_READ, 8'h00, 8'h00, 8'h00, 8'd7);
        send_item(ACT_CLEAR, 8'd255, 8'h00, 8'h00, 8'd255);
        send_item(ACT_READ, 8'h00, 8'h00, 8'h00, 8'd255);
        send_item(ACT_ADD, 8'ha5, 8'h00, 8'h00, 8'h00);
        send_item(ACT_READ, 8'h00, 8'h00, 8'h00, 8'ha5);

        // color mode, each channel and the empty selector
        write_config(1'b1, CH_ONE);
        send_item(ACT_ADD, 8'd1, 8'd2, 8'd3, 8'd0);
        write_config(1'b1, CH_TWO);
        send_item(ACT_ADD, 8'd1, 8'd2, 8'd3, 8'd0);
        write_config(1'b1, CH_NONE);
        send_item(ACT_ADD, 8'd1, 8'd2, 8'd3, 8'd0);
        write_config(1'b1, CH_ZERO);
        send_item(ACT_ADD, 8'd1, 8'd2, 8'd3, 8'd0);
        send_item(ACT_READ, 8'h00, 8'h00, 8'h00, 8'd1);
        send_item(ACT_READ, 8'h00, 8'h00, 8'h00, 8'd2);
        send_item(ACT_READ, 8'h00, 8'h00, 8'h00, 8'd3);

        for (int phase = 0; phase < PHASES; phase++) begin
            idle_on <= (phase != PHASES - 1) && (phase == 0 || $urandom_range(0, 3) != 0);
            write_config(phase_color[phase], phase_chan[phase]);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
                random_item();
        end

        wait_for_counts();
        if (fail_count == 0 && reads_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
